// ===== hw/rtl/dprh_pkg.sv =====
// Shared types and constants for the depth pixel to range/height pipeline.
package dprh_pkg;

  // Pixel index bits kept from pix_row / pix_col (at most 12, the pixel port width).
  localparam int unsigned COORD_BITS = 12;
  localparam logic [11:0] PIX_MASK   = 12'((64'd1 << COORD_BITS) - 64'd1);

  // Front pipeline depth: z, offsets, products, rounding, saturation, squares.
  localparam int unsigned FRONT_STAGES = 9;

  // Square root: one result bit per stage.
  localparam int unsigned ROOT_BITS = 40;
  localparam int unsigned RAD_BITS  = 2 * ROOT_BITS;

  // Stream payload widths (byte aligned).
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 184;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    CFG_INV_DEPTH_SCALE = 8'd0,
    CFG_CENTER_COL      = 8'd1,
    CFG_CENTER_ROW      = 8'd2,
    CFG_INV_FOCAL_COL   = 8'd3,
    CFG_INV_FOCAL_ROW   = 8'd4
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [24:0] RST_INV_DEPTH_SCALE = 25'd16777;
  localparam logic [15:0] RST_CENTER_COL      = 16'd5120;
  localparam logic [15:0] RST_CENTER_ROW      = 16'd3840;
  localparam logic [24:0] RST_INV_FOCAL_COL   = 25'd33554;
  localparam logic [24:0] RST_INV_FOCAL_ROW   = 25'd33554;

  typedef struct packed {
    logic [24:0] inv_depth_scale;
    logic [15:0] center_col;
    logic [15:0] center_row;
    logic [24:0] inv_focal_col;
    logic [24:0] inv_focal_row;
  } cfg_t;

  // Fields that ride alongside the square root.
  typedef struct packed {
    logic        point_valid;
    logic [39:0] coord_x;
    logic [39:0] coord_y;
    logic [31:0] coord_z;
  } side_t;

endpackage

// ===== hw/rtl/dprh_front.sv =====
// Front pipeline: depth scaling, back-projection, saturation and squared range.
module dprh_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dprh_pkg::cfg_t                  cfg_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [11:0]                     pix_row_i,
  input  logic [11:0]                     pix_col_i,
  input  logic [15:0]                     raw_depth_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [dprh_pkg::RAD_BITS-1:0]   rad_o,
  output dprh_pkg::side_t                 side_o
);

  localparam int unsigned NS = dprh_pkg::FRONT_STAGES;
  localparam logic [45:0] LIM_POS = 46'((64'd1 << 39) - 64'd1);
  localparam logic [45:0] LIM_NEG = 46'(64'd1 << 39);

  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] ld;

  // A stage takes a beat when it is empty or its own beat moves on.
  always_comb begin
    rdy[NS] = ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign vin     = {vld_q[NS-2:0], valid_i};
  assign ld      = vin & rdy[NS-1:0];
  assign ready_o = rdy[0];
  assign valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~rdy[NS-1:0]) | ld;
    end
  end

  // Stage 1: depth product and signed pixel offsets in Q.4
  logic [11:0] row_m, col_m;
  logic [15:0] p16r, p16c;
  logic        nr_d, nc_d;
  logic [15:0] dr_d, dc_d;

  assign row_m = pix_row_i & dprh_pkg::PIX_MASK;
  assign col_m = pix_col_i & dprh_pkg::PIX_MASK;
  assign p16r  = {row_m, 4'b0000};
  assign p16c  = {col_m, 4'b0000};
  assign nr_d  = p16r < cfg_i.center_row;
  assign nc_d  = p16c < cfg_i.center_col;
  assign dr_d  = nr_d ? (cfg_i.center_row - p16r) : (p16r - cfg_i.center_row);
  assign dc_d  = nc_d ? (cfg_i.center_col - p16c) : (p16c - cfg_i.center_col);

  logic [40:0] s1_zp_q;
  logic [15:0] s1_dr_q, s1_dc_q;
  logic        s1_nr_q, s1_nc_q, s1_pv_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s1_zp_q <= 41'(raw_depth_i) * 41'(cfg_i.inv_depth_scale);
      s1_dr_q <= dr_d;
      s1_dc_q <= dc_d;
      s1_nr_q <= nr_d;
      s1_nc_q <= nc_d;
      s1_pv_q <= (raw_depth_i != 16'd0);
    end
  end

  // Stage 2: round z half up to Q16.16, saturate
  logic [41:0] zr;
  logic [31:0] z_d;

  assign zr  = {1'b0, s1_zp_q} + 42'd128;
  assign z_d = (zr[41:40] != 2'b00) ? 32'hFFFF_FFFF : zr[39:8];

  logic [31:0] s2_z_q;
  logic [15:0] s2_dr_q, s2_dc_q;
  logic        s2_nr_q, s2_nc_q, s2_pv_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s2_z_q  <= z_d;
      s2_dr_q <= s1_dr_q;
      s2_dc_q <= s1_dc_q;
      s2_nr_q <= s1_nr_q;
      s2_nc_q <= s1_nc_q;
      s2_pv_q <= s1_pv_q;
    end
  end

  // Stage 3: offset times z (Q.20)
  logic [47:0] s3_mr_q, s3_mc_q;
  logic [31:0] s3_z_q;
  logic        s3_nr_q, s3_nc_q, s3_pv_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      s3_mr_q <= 48'(s2_dr_q) * 48'(s2_z_q);
      s3_mc_q <= 48'(s2_dc_q) * 48'(s2_z_q);
      s3_z_q  <= s2_z_q;
      s3_nr_q <= s2_nr_q;
      s3_nc_q <= s2_nc_q;
      s3_pv_q <= s2_pv_q;
    end
  end

  // Stage 4: times the focal reciprocal, as two 24x25 partial products
  logic [48:0] s4_ar_q, s4_br_q, s4_ac_q, s4_bc_q;
  logic [31:0] s4_z_q;
  logic        s4_nr_q, s4_nc_q, s4_pv_q;

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      s4_ar_q <= 49'(s3_mr_q[47:24]) * 49'(cfg_i.inv_focal_row);
      s4_br_q <= 49'(s3_mr_q[23:0]) * 49'(cfg_i.inv_focal_row);
      s4_ac_q <= 49'(s3_mc_q[47:24]) * 49'(cfg_i.inv_focal_col);
      s4_bc_q <= 49'(s3_mc_q[23:0]) * 49'(cfg_i.inv_focal_col);
      s4_z_q  <= s3_z_q;
      s4_nr_q <= s3_nr_q;
      s4_nc_q <= s3_nc_q;
      s4_pv_q <= s3_pv_q;
    end
  end

  // Stage 5: combine partials and round magnitude to Q.16
  logic [49:0] ir, ic;
  logic [45:0] rr_d, rc_d;

  assign ir   = 50'({s4_ar_q[3:0], 24'd0}) + 50'(s4_br_q) + 50'(64'd1 << 27);
  assign ic   = 50'({s4_ac_q[3:0], 24'd0}) + 50'(s4_bc_q) + 50'(64'd1 << 27);
  assign rr_d = 46'(s4_ar_q[48:4]) + 46'(ir[49:28]);
  assign rc_d = 46'(s4_ac_q[48:4]) + 46'(ic[49:28]);

  logic [45:0] s5_rr_q, s5_rc_q;
  logic [31:0] s5_z_q;
  logic        s5_nr_q, s5_nc_q, s5_pv_q;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      s5_rr_q <= rr_d;
      s5_rc_q <= rc_d;
      s5_z_q  <= s4_z_q;
      s5_nr_q <= s4_nr_q;
      s5_nc_q <= s4_nc_q;
      s5_pv_q <= s4_pv_q;
    end
  end

  // Stage 6: saturate to the signed 40-bit range, apply sign
  logic [45:0] lim_r, lim_c;
  logic [39:0] my_d, mx_d;

  assign lim_r = s5_nr_q ? LIM_NEG : LIM_POS;
  assign lim_c = s5_nc_q ? LIM_NEG : LIM_POS;
  assign my_d  = (s5_rr_q > lim_r) ? lim_r[39:0] : s5_rr_q[39:0];
  assign mx_d  = (s5_rc_q > lim_c) ? lim_c[39:0] : s5_rc_q[39:0];

  logic [39:0] s6_my_q, s6_mx_q, s6_y_q, s6_x_q;
  logic [31:0] s6_z_q;
  logic        s6_pv_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      s6_my_q <= my_d;
      s6_mx_q <= mx_d;
      s6_y_q  <= s5_nr_q ? (~my_d + 40'd1) : my_d;
      s6_x_q  <= s5_nc_q ? (~mx_d + 40'd1) : mx_d;
      s6_z_q  <= s5_z_q;
      s6_pv_q <= s5_pv_q;
    end
  end

  // Stage 7: 20-bit partial products of each square
  logic [39:0] s7_xhh_q, s7_xhl_q, s7_xll_q;
  logic [39:0] s7_yhh_q, s7_yhl_q, s7_yll_q;
  dprh_pkg::side_t s7_side_q;

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      s7_xhh_q <= 40'(s6_mx_q[39:20]) * 40'(s6_mx_q[39:20]);
      s7_xhl_q <= 40'(s6_mx_q[39:20]) * 40'(s6_mx_q[19:0]);
      s7_xll_q <= 40'(s6_mx_q[19:0]) * 40'(s6_mx_q[19:0]);
      s7_yhh_q <= 40'(s6_my_q[39:20]) * 40'(s6_my_q[39:20]);
      s7_yhl_q <= 40'(s6_my_q[39:20]) * 40'(s6_my_q[19:0]);
      s7_yll_q <= 40'(s6_my_q[19:0]) * 40'(s6_my_q[19:0]);
      s7_side_q.point_valid <= s6_pv_q;
      s7_side_q.coord_x     <= s6_x_q;
      s7_side_q.coord_y     <= s6_y_q;
      s7_side_q.coord_z     <= s6_z_q;
    end
  end

  // Stage 8: assemble each square; cross term counts twice
  logic [79:0] s8_sx_q, s8_sy_q;
  dprh_pkg::side_t s8_side_q;

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      s8_sx_q   <= {s7_xhh_q, 40'd0} + (80'(s7_xhl_q) << 21) + 80'(s7_xll_q);
      s8_sy_q   <= {s7_yhh_q, 40'd0} + (80'(s7_yhl_q) << 21) + 80'(s7_yll_q);
      s8_side_q <= s7_side_q;
    end
  end

  // Stage 9: sum of squares
  logic [79:0] s9_rad_q;
  dprh_pkg::side_t s9_side_q;

  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      s9_rad_q  <= s8_sx_q + s8_sy_q;
      s9_side_q <= s8_side_q;
    end
  end

  assign rad_o  = s9_rad_q;
  assign side_o = s9_side_q;

endmodule

// ===== hw/rtl/dprh_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with side fields.
module dprh_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [dprh_pkg::RAD_BITS-1:0]   rad_i,
  input  dprh_pkg::side_t                 side_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [dprh_pkg::ROOT_BITS-1:0]  root_o,
  output dprh_pkg::side_t                 side_o
);

  localparam int unsigned NS = dprh_pkg::ROOT_BITS;
  localparam int unsigned RW = dprh_pkg::RAD_BITS;

  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] ld;

  logic [RW-1:0]          rem_q  [NS];
  logic [NS-1:0]          root_q [NS];
  dprh_pkg::side_t        side_q [NS];

  always_comb begin
    rdy[NS] = ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign vin     = {vld_q[NS-2:0], valid_i};
  assign ld      = vin & rdy[NS-1:0];
  assign ready_o = rdy[0];
  assign valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~rdy[NS-1:0]) | ld;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stg
    localparam int unsigned B = NS - 1 - k;

    logic [RW-1:0]   rem_in;
    logic [NS-1:0]   root_in;
    dprh_pkg::side_t side_in;
    logic [RW:0]     trial;
    logic [RW:0]     diff;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    assign trial = ((RW+1)'(root_in) << (B + 1)) + ((RW+1)'(1) << (2 * B));
    assign take  = trial <= {1'b0, rem_in};
    assign diff  = {1'b0, rem_in} - trial;

    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        rem_q[k]  <= take ? diff[RW-1:0] : rem_in;
        root_q[k] <= take ? (root_in | (NS'(1) << B)) : root_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign root_o = root_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule

// ===== hw/rtl/depth_pixel_to_range_height.sv =====
// Top level: depth pixel back-projection to x, y, z, planar range and height.
//
// A depth pixel (row, column, raw depth) enters as one beat on the s_axis
// channel; one result beat leaves on m_axis for every input beat, in order.
// m_axis_tuser carries point_valid; a zero raw depth gives point_valid = 0
// and all-zero coordinates. The camera registers are written through the
// cfg channel (cfg_ready_o is always high); write them only while no beat
// is in flight. Indexes beyond the register list are ignored.
//
// Each beat passes through 9 stages for z, the projected coordinates and the
// sum of squares, then 40 stages of the square root, one root bit per stage.
// Throughput is one beat per cycle while m_axis_tready is high.
// Each stage keeps its own valid bit and loads whenever it is empty or its
// beat moves on, so when m_axis_tready is low the pipeline fills its bubbles
// and keeps taking input until every stage holds a beat; nothing is lost or
// repeated. Reset clears all valid bits and loads the default camera model.
module depth_pixel_to_range_height (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // pix_row [11:0], pix_col [23:12], raw_depth [39:24]
  input  logic [dprh_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // coord_x [39:0], coord_y [79:40], coord_z [111:80],
  // planar_range [151:112], half_depth [182:152], zero [183]
  output logic [dprh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // point_valid [0]
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [7:0]                           cfg_index_i,
  input  logic [31:0]                          cfg_data_i
);

  dprh_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_depth_scale <= dprh_pkg::RST_INV_DEPTH_SCALE;
      cfg_q.center_col      <= dprh_pkg::RST_CENTER_COL;
      cfg_q.center_row      <= dprh_pkg::RST_CENTER_ROW;
      cfg_q.inv_focal_col   <= dprh_pkg::RST_INV_FOCAL_COL;
      cfg_q.inv_focal_row   <= dprh_pkg::RST_INV_FOCAL_ROW;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dprh_pkg::CFG_INV_DEPTH_SCALE: cfg_q.inv_depth_scale <= cfg_data_i[24:0];
        dprh_pkg::CFG_CENTER_COL:      cfg_q.center_col      <= cfg_data_i[15:0];
        dprh_pkg::CFG_CENTER_ROW:      cfg_q.center_row      <= cfg_data_i[15:0];
        dprh_pkg::CFG_INV_FOCAL_COL:   cfg_q.inv_focal_col   <= cfg_data_i[24:0];
        dprh_pkg::CFG_INV_FOCAL_ROW:   cfg_q.inv_focal_row   <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  logic                                 fr_valid;
  logic                                 fr_ready;
  logic [dprh_pkg::RAD_BITS-1:0]        fr_rad;
  dprh_pkg::side_t                      fr_side;
  logic [dprh_pkg::ROOT_BITS-1:0]       root;
  dprh_pkg::side_t                      out_side;

  dprh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .pix_row_i   (s_axis_tdata[11:0]),
    .pix_col_i   (s_axis_tdata[23:12]),
    .raw_depth_i (s_axis_tdata[39:24]),
    .valid_o     (fr_valid),
    .ready_i     (fr_ready),
    .rad_o       (fr_rad),
    .side_o      (fr_side)
  );

  dprh_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .root_o  (root),
    .side_o  (out_side)
  );

  assign m_axis_tuser = out_side.point_valid;
  assign m_axis_tdata = {1'b0, out_side.coord_z[31:1], root, out_side.coord_z,
                         out_side.coord_y, out_side.coord_x};

endmodule

// ===== hw/rtl/dprh_chk.sv =====
// Port-level checker for the depth pixel pipeline, bound to the top level.
module dprh_chk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tready,
  input  logic [dprh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 m_axis_tuser,
  input  logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready
);

  logic [39:0] x_v, y_v, ax, ay, rng;

  assign x_v = m_axis_tdata[39:0];
  assign y_v = m_axis_tdata[79:40];
  assign rng = m_axis_tdata[151:112];
  assign ax  = x_v[39] ? (~x_v + 40'd1) : x_v;
  assign ay  = y_v[39] ? (~y_v + 40'd1) : y_v;

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Input back-pressure only when the pipeline is full up to the output.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

  // An invalid point gives an all-zero beat.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid point carries nonzero fields");

  // Height is z with the low bit dropped.
  a_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[182:152] == m_axis_tdata[111:81])
    else $error("half_depth does not match coord_z");

  // Planar range covers each coordinate magnitude.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rng >= ax) && (rng >= ay))
    else $error("planar_range below a coordinate magnitude");

endmodule

bind depth_pixel_to_range_height dprh_chk u_dprh_chk (.*);
